### rtl/tfb_pkg.sv
// Package for the text frame buffer flush unit: geometry, word types and font lookup.
// Used by every module in this block; it depends on nothing else.
package tfb_pkg;

  localparam int unsigned ROW_BYTES  = 128;
  localparam int unsigned PAGE_ROWS  = 8;
  localparam int unsigned LINE_CHARS = 21;
  localparam int unsigned MAX_BURST  = 32;

  localparam int unsigned COL_W  = $clog2(ROW_BYTES);
  localparam int unsigned ROW_W  = (PAGE_ROWS > 1) ? $clog2(PAGE_ROWS) : 1;
  localparam int unsigned ADDR_W = COL_W + ROW_W;
  localparam int unsigned DEPTH  = ROW_BYTES << ROW_W;

  localparam logic [1:0] REQ_LINE  = 2'd0;
  localparam logic [1:0] REQ_CLEAR = 2'd1;
  localparam logic [1:0] REQ_SERV  = 2'd2;

  localparam logic [7:0] CMD_PAGE  = 8'hB0;
  localparam logic [7:0] CMD_COLLO = 8'h00;
  localparam logic [7:0] CMD_COLHI = 8'h10;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] line_row;
    logic [5:0] char_pos;
    logic [7:0] char_code;
    logic       char_present;
    logic       line_end;
    logic [5:0] burst_limit;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       is_last;
  } out_word_t;

  // Glyph column lookup; column index 0..4 of the folded character.
  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic [2:0] col);
    logic [7:0]  c;
    logic [39:0] g;
    c = code;
    if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
    case (c)
      "0": g = 40'h3E5149453E; "1": g = 40'h00427F4000;
      "2": g = 40'h4261514946; "3": g = 40'h2141454B31;
      "4": g = 40'h1814127F10; "5": g = 40'h2745454539;
      "6": g = 40'h3C4A494930; "7": g = 40'h0171090503;
      "8": g = 40'h3649494936; "9": g = 40'h064949291E;
      "A": g = 40'h7E1111117E; "B": g = 40'h7F49494936;
      "C": g = 40'h3E41414122; "D": g = 40'h7F4141221C;
      "E": g = 40'h7F49494941; "F": g = 40'h7F09090901;
      "G": g = 40'h3E4149497A; "H": g = 40'h7F0808087F;
      "I": g = 40'h00417F4100; "J": g = 40'h2040413F01;
      "K": g = 40'h7F08142241; "L": g = 40'h7F40404040;
      "M": g = 40'h7F020C027F; "N": g = 40'h7F0408107F;
      "O": g = 40'h3E4141413E; "P": g = 40'h7F09090906;
      "Q": g = 40'h3E4151215E; "R": g = 40'h7F09192946;
      "S": g = 40'h4649494931; "T": g = 40'h01017F0101;
      "U": g = 40'h3F4040403F; "V": g = 40'h1F2040201F;
      "W": g = 40'h3F4038403F; "X": g = 40'h6314081463;
      "Y": g = 40'h0708700807; "Z": g = 40'h6151494543;
      "+": g = 40'h08083E0808; "-": g = 40'h0808080808;
      ".": g = 40'h0060600000; "/": g = 40'h2010080402;
      ":": g = 40'h0036360000; "%": g = 40'h6313086463;
      "=": g = 40'h1414141414; "_": g = 40'h4040404040;
      " ": g = 40'h0000000000;
      default: g = 40'h0201510906;
    endcase
    case (col)
      3'd0: glyph_col = g[39:32];
      3'd1: glyph_col = g[31:24];
      3'd2: glyph_col = g[23:16];
      3'd3: glyph_col = g[15:8];
      3'd4: glyph_col = g[7:0];
      default: glyph_col = 8'h00;
    endcase
  endfunction

endpackage

### rtl/text_framebuffer_dirty_page_flush_unit.sv
// Top level of the text frame buffer flush unit: sequencer around the frame store.
// Depends on tfb_pkg and tfb_store.
//
//  channel | dir | handshake            | payload
//  in      | in  | in_valid_i/in_stall_o | tfb_pkg::in_word_t
//  out     | out | out_valid_o/out_stall_i| tfb_pkg::out_word_t
//
// A character writes six bytes, each a read state then a compare-write state.
// A line end adds a read and a compare-write per tail byte and a closing read to end
// the line; a service step is limited by the single store read port and the output
// register.
// After reset, and after each clear word, a clearing pass zeroes the store one byte a
// cycle while no word is accepted. A stalled output holds the sequencer.
module text_framebuffer_dirty_page_flush_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tfb_pkg::in_word_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tfb_pkg::out_word_t  out_data_o
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_CMD  = 3'd4;
  localparam logic [2:0] S_DAT  = 3'd5;
  localparam logic [2:0] S_DRN  = 3'd6;

  localparam int unsigned CW = tfb_pkg::COL_W + 1;
  localparam int unsigned RW = tfb_pkg::ROW_W;
  localparam logic [CW-1:0] ROWB = CW'(tfb_pkg::ROW_BYTES);
  localparam logic [6:0] LIMB = 7'(tfb_pkg::MAX_BURST);

  logic [2:0]    state_q, state_d;
  logic [tfb_pkg::ADDR_W:0] clr_q, clr_d;
  logic [7:0]    dirty_q, dirty_d;
  logic          flushing_q, flushing_d, changed_q, changed_d;
  logic [RW-1:0] frow_q, frow_d;
  logic [CW-1:0] fcol_q, fcol_d;
  tfb_pkg::in_word_t req_q, req_d;
  logic [CW-1:0] col_q, col_d;   // current write column
  logic [CW-1:0] cend_q, cend_d; // glyph end column
  logic          tail_q, tail_d; // writing the line tail
  logic [1:0]    cmd_q, cmd_d;
  logic [6:0]    left_q, left_d; // data words still to send
  logic          ov_q, ov_d;
  tfb_pkg::out_word_t od_q, od_d;
  logic          pend_q, pend_d; // read data waiting to go out
  logic          plast_q, plast_d;

  logic                      we;
  logic [tfb_pkg::ADDR_W-1:0] waddr, raddr;
  logic [7:0]                wdata, rdata;

  tfb_store u_store (.clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
                     .raddr_i(raddr), .rdata_o(rdata));

  logic        out_free;
  logic [7:0]  gval;
  logic [CW-1:0] gofs;
  logic [6:0]  lim;
  logic [CW-1:0] rem;
  logic [CW-1:0] pcol;
  logic [RW-1:0] pick;
  logic          any;

  assign in_stall_o  = (state_q != S_IDLE) || ov_q;
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign out_free    = !ov_q || !out_stall_i;

  // Lowest dirty page.
  always_comb begin
    pick = '0;
    any  = 1'b0;
    for (int p = tfb_pkg::PAGE_ROWS - 1; p >= 0; p--) begin
      if (dirty_q[p]) begin
        pick = RW'(p);
        any  = 1'b1;
      end
    end
  end

  // Main sequencer.
  always_comb begin
    state_d = state_q; clr_d = clr_q; dirty_d = dirty_q; flushing_d = flushing_q;
    changed_d = changed_q; frow_d = frow_q; fcol_d = fcol_q; req_d = req_q;
    col_d = col_q; cend_d = cend_q; tail_d = tail_q; cmd_d = cmd_q; left_d = left_q;
    ov_d = ov_q && out_stall_i; od_d = od_q; pend_d = pend_q; plast_d = plast_q;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    gofs = col_q - cend_q + CW'(6);
    gval = (tail_q || gofs == CW'(5)) ? 8'h00 :
           tfb_pkg::glyph_col(req_q.char_code, gofs[2:0]);
    lim  = (req_q.burst_limit > 6'(LIMB)) ? LIMB : 7'(req_q.burst_limit);
    rem  = ROWB - fcol_q;
    // Column of the most recent flush read, re-read while its word waits.
    pcol = fcol_q - 1'b1;
    case (state_q)
      S_CLR: begin
        we = 1'b1; waddr = clr_q[tfb_pkg::ADDR_W-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q[tfb_pkg::ADDR_W]) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          req_d = in_data_i;
          case (in_data_i.req_type)
            tfb_pkg::REQ_LINE: begin
              if (32'(in_data_i.line_row) < tfb_pkg::PAGE_ROWS) begin
                if (in_data_i.char_present &&
                    32'(in_data_i.char_pos) < tfb_pkg::LINE_CHARS) begin
                  col_d  = CW'(32'(in_data_i.char_pos) * 6);
                  cend_d = CW'(32'(in_data_i.char_pos) * 6 + 6);
                  tail_d = 1'b0;
                  state_d = S_RD;
                end else if (in_data_i.line_end) begin
                  col_d = CW'((32'(in_data_i.char_pos) + 32'(in_data_i.char_present)
                               > tfb_pkg::LINE_CHARS ? tfb_pkg::LINE_CHARS :
                               32'(in_data_i.char_pos) + 32'(in_data_i.char_present)) * 6);
                  tail_d = 1'b1;
                  state_d = S_RD;
                end
              end
            end
            tfb_pkg::REQ_CLEAR: begin
              dirty_d = 8'hFF; flushing_d = 1'b0; frow_d = '0; fcol_d = '0;
              changed_d = 1'b0; clr_d = '0; state_d = S_CLR;
            end
            tfb_pkg::REQ_SERV: begin
              if (in_data_i.burst_limit != '0) begin
                if (!flushing_q && any) begin
                  flushing_d = 1'b1; frow_d = pick; fcol_d = '0;
                  cmd_d = 2'd0; state_d = S_CMD;
                end else if (flushing_q) begin
                  state_d = S_DAT; left_d = 7'd0; pend_d = 1'b0;
                  cmd_d = 2'd3;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        // Columns past the row end are dropped; the tail ends there too.
        if (col_q >= ROWB) begin
          if (req_q.line_end) begin
            if (changed_q) dirty_d = dirty_q | (8'd1 << req_q.line_row);
            changed_d = 1'b0;
          end
          state_d = S_IDLE;
        end else begin
          raddr = {req_q.line_row[RW-1:0], col_q[CW-2:0]};
          state_d = S_WR;
        end
      end
      S_WR: begin
        we = 1'b1; waddr = {req_q.line_row[RW-1:0], col_q[CW-2:0]}; wdata = gval;
        if (rdata != gval) changed_d = 1'b1;
        col_d = col_q + 1'b1;
        state_d = S_RD;
        if (!tail_q && col_q + 1'b1 == cend_q) begin
          if (req_q.line_end) tail_d = 1'b1;
          else state_d = S_IDLE;
        end
        if (!tail_q && col_q + 1'b1 == cend_q && req_q.line_end && col_q + 1'b1 >= ROWB &&
            rdata != gval) begin
          changed_d = 1'b1;
        end
      end
      S_CMD: begin
        if (out_free) begin
          ov_d = 1'b1; od_d.is_command = 1'b1; od_d.is_last = 1'b0;
          case (cmd_q)
            2'd0: od_d.out_byte = tfb_pkg::CMD_PAGE | 8'(frow_q);
            2'd1: od_d.out_byte = tfb_pkg::CMD_COLLO;
            default: od_d.out_byte = tfb_pkg::CMD_COLHI;
          endcase
          cmd_d = cmd_q + 1'b1;
          if (cmd_q == 2'd2) begin
            state_d = S_DAT; left_d = 7'd0; pend_d = 1'b0; cmd_d = 2'd3;
          end
        end
      end
      S_DAT: begin
        raddr = {frow_q, pcol[CW-2:0]};
        // First entry loads the burst count; then one read per free output slot.
        if (cmd_q == 2'd3) begin
          left_d = (rem > CW'(lim)) ? lim : 7'(rem);
          cmd_d = 2'd0;
        end else if (!pend_q || out_free) begin
          if (pend_q) begin
            ov_d = 1'b1; od_d.out_byte = rdata; od_d.is_command = 1'b0;
            od_d.is_last = plast_q; pend_d = 1'b0;
          end
          if (left_q != '0) begin
            raddr = {frow_q, fcol_q[CW-2:0]};
            pend_d = 1'b1; plast_d = (left_q == 7'd1);
            left_d = left_q - 1'b1; fcol_d = fcol_q + 1'b1;
          end else if (!pend_q || out_free) begin
            if (fcol_q >= ROWB) begin
              dirty_d = dirty_q & ~(8'd1 << frow_q);
              flushing_d = 1'b0; fcol_d = '0;
            end
            state_d = pend_q ? S_DRN : S_IDLE;
          end
        end
      end
      S_DRN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; clr_q <= '0; dirty_q <= 8'hFF; flushing_q <= 1'b0;
      changed_q <= 1'b0; frow_q <= '0; fcol_q <= '0; col_q <= '0; cend_q <= '0;
      tail_q <= 1'b0; cmd_q <= '0; left_q <= '0; ov_q <= 1'b0; pend_q <= 1'b0;
      plast_q <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; dirty_q <= dirty_d; flushing_q <= flushing_d;
      changed_q <= changed_d; frow_q <= frow_d; fcol_q <= fcol_d; col_q <= col_d;
      cend_q <= cend_d; tail_q <= tail_d; cmd_q <= cmd_d; left_q <= left_d;
      ov_q <= ov_d; pend_q <= pend_d; plast_q <= plast_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    od_q  <= od_d;
  end

endmodule

### rtl/tfb_store.sv
// Frame store memory: one write port and one registered read port.
// Depends on tfb_pkg for its geometry.
module tfb_store (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [tfb_pkg::ADDR_W-1:0] waddr_i,
  input  logic [7:0]                wdata_i,
  input  logic [tfb_pkg::ADDR_W-1:0] raddr_i,
  output logic [7:0]                rdata_o
);

  logic [7:0] mem [tfb_pkg::DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule
